>>> rtl/core/ltkm_pkg.sv
// ----------------------------------------------------------------------------
// ltkm_pkg: shared types and codes of the loser-tree k-way merge selector
// Controller states, command and status bundles, and result status codes.
// ----------------------------------------------------------------------------
package ltkm_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_NOT_READY = 2'd0;
  localparam logic [1:0] STATUS_WINNER    = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

  // Number of ways after reset.
  localparam logic [3:0] CFG_WAYS_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NODE,
    S_RD_KEY,
    S_CMP,
    S_FINISH,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input item is taken this cycle
    logic rd_key;    // node read data is back, latch the resident entry
    logic cmp_step;  // compare at the current node and climb one level
    logic finish;    // the climbing contender becomes the overall winner
    logic out_load;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_replay;  // current input is a head item of a way in range
    logic walk_empty;   // that way's leaf sits directly below the root
    logic walk_last;    // the node being compared is the last below the root
    logic out_full;     // the result register holds an item not yet taken
  } sts_t;

endpackage

>>> rtl/core/loser_tree_kway_merge_top.sv
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top: loser-tree winner selector for a k-way merge
// Keeps the tree over the front keys of up to WAYS ways and reports the way
// with the smallest key after every input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_stall) are either a start item (in_kind = 0),
//   which clears the tree, or a head item giving a way's new front key or
//   marking it exhausted. Each input item yields exactly one result item on
//   out_valid/out_stall: not-ready, winner (way and key) or all-exhausted.
//   cfg_we/cfg_ways_in_use sets the number of ways; write it only while idle.
// Sequence:
//   A head item replays L tree levels, L = floor(log2((way + n) / 2)) + 1,
//   three for eight ways. Each level is a node memory read followed by a
//   front-key memory read and compare; after the last level a finish step
//   takes the winner, and the result is loaded before the next item can be
//   accepted. With one way in use there is no level to replay and a head
//   item goes straight to the finish step; start items and ignored heads go
//   straight to the result load, which returns the controller to idle.
// Reset and stall:
//   After reset the tree is empty and eight ways are in use. A stalled result
//   holds in the output register; the next item is still accepted, and its
//   result waits until the register drains.
// ----------------------------------------------------------------------------
module loser_tree_kway_merge_top
  import ltkm_pkg::*;
#(
  parameter int WAYS     = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_ways_in_use,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_kind,
  input  logic [$clog2(WAYS)-1:0] in_way,
  input  logic                    in_has_key,
  input  logic [KEY_BITS-1:0]     in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [$clog2(WAYS)-1:0] out_winner_way,
  output logic [KEY_BITS-1:0]     out_winner_key
);

  cmd_t cmd;
  sts_t sts;

  ltkm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ltkm_dpath #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_ways_in_use (cfg_ways_in_use),
    .in_kind         (in_kind),
    .in_way          (in_way),
    .in_has_key      (in_has_key),
    .in_key          (in_key),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_winner_way  (out_winner_way),
    .out_winner_key  (out_winner_key)
  );

endmodule

>>> rtl/core/ltkm_ctrl.sv
// ----------------------------------------------------------------------------
// ltkm_ctrl: sequencer of the loser-tree merge selector
// Walks one replay from leaf to root, one tree level per read-key and
// compare state pair, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ltkm_ctrl
  import ltkm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.head_replay) begin
            state_nxt = sts.walk_empty ? S_FINISH : S_RD_NODE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      // The node read for the first level is in flight.
      S_RD_NODE: begin
        state_nxt = S_RD_KEY;
      end
      S_RD_KEY: begin
        cmd.rd_key = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        state_nxt    = sts.walk_last ? S_FINISH : S_RD_KEY;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> rtl/core/ltkm_dpath.sv
// ----------------------------------------------------------------------------
// ltkm_dpath: datapath of the loser-tree merge selector
// Holds the node and front-key memories, the per-way live flags, the
// climbing contender, the winner and the result register.
// ----------------------------------------------------------------------------
module ltkm_dpath
  import ltkm_pkg::*;
#(
  parameter int WAYS     = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic                        cfg_we,
  input  logic [3:0]                  cfg_ways_in_use,
  input  logic                        in_kind,
  input  logic [$clog2(WAYS)-1:0]     in_way,
  input  logic                        in_has_key,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [$clog2(WAYS)-1:0]     out_winner_way,
  output logic [KEY_BITS-1:0]         out_winner_key
);

  localparam int WAY_W  = $clog2(WAYS);
  localparam int NODE_W = $clog2(WAYS + 2);
  localparam int N_W    = $clog2(WAYS + 1);
  localparam int CW     = (N_W > 4) ? N_W : 4;
  localparam int SW     = CW + 1;

  localparam logic [NODE_W-1:0] NODE_UNSET     = NODE_W'(WAYS);
  localparam logic [NODE_W-1:0] NODE_EXHAUSTED = NODE_W'(WAYS + 1);

  // Configuration and effective way count.
  logic [3:0]    cfg_ways_r;
  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] n_eff;
  logic [SW-1:0] leaf_sum;
  logic [WAY_W-1:0] first_parent;
  logic          in_range;

  // Tree state.
  logic [NODE_W-1:0]   node_mem [WAYS];
  logic [WAYS-1:0]     node_vld_r;
  logic [NODE_W-1:0]   node_rd_r;
  logic                node_rd_vld_r;
  logic [WAY_W-1:0]    node_raddr;
  logic [KEY_BITS-1:0] key_mem [WAYS];
  logic [KEY_BITS-1:0] key_rd_r;
  logic [WAY_W-1:0]    key_raddr;
  logic [WAYS-1:0]     way_live_r;
  logic [NODE_W-1:0]   node0_r;
  logic [KEY_BITS-1:0] win_key_r;

  // Replay walk.
  logic [WAY_W-1:0]    parent_r;
  logic [WAY_W-1:0]    parent_up;
  logic [NODE_W-1:0]   next_r, next_nxt;
  logic [KEY_BITS-1:0] next_key_r, next_key_nxt;
  logic [NODE_W-1:0]   held_r;
  logic [NODE_W-1:0]   held_c;
  logic                live_next;
  logic                live_held;
  logic                arr_loses;
  logic                node_we;
  logic [NODE_W-1:0]   node_wd;

  // Result.
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [WAY_W-1:0]    out_way_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [1:0]          res_status;
  logic                top_live;

  always_comb begin
    cfg_ext = CW'(cfg_ways_r);
    if (cfg_ext == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > CW'(WAYS)) begin
      n_eff = CW'(WAYS);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign in_range     = (CW'(in_way) < n_eff);
  assign leaf_sum     = SW'(in_way) + SW'(n_eff);
  assign first_parent = WAY_W'(leaf_sum >> 1);
  assign parent_up    = parent_r >> 1;

  assign sts.head_replay = in_kind && in_range;
  assign sts.walk_empty  = (first_parent == '0);
  assign sts.walk_last   = (parent_up == '0);
  assign sts.out_full    = out_valid_r;

  // A node that was never written since the last start reads as unset.
  assign held_c     = node_rd_vld_r ? node_rd_r : NODE_UNSET;
  assign node_raddr = cmd.cmp_step ? parent_up : parent_r;
  assign key_raddr  = (held_c < NODE_UNSET) ? held_c[WAY_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ways_r <= CFG_WAYS_RESET;
    end else if (cfg_we) begin
      cfg_ways_r <= cfg_ways_in_use;
    end
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    node_rd_r <= node_mem[node_raddr];
    if (node_we) begin
      node_mem[parent_r] <= node_wd;
    end
  end

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[key_raddr];
    if (cmd.accept && sts.head_replay) begin
      key_mem[in_way] <= in_has_key ? in_key : '0;
    end
  end

  // Comparison at one node. An exhausted or stale way loses to any way that
  // still has a key; between two such ways the arriving one stays on top.
  assign live_next = (next_r < NODE_UNSET) && way_live_r[next_r[WAY_W-1:0]];
  assign live_held = (held_r < NODE_UNSET) && way_live_r[held_r[WAY_W-1:0]];

  always_comb begin
    if (!live_next) begin
      arr_loses = live_held;
    end else if (!live_held) begin
      arr_loses = 1'b0;
    end else begin
      arr_loses = (next_key_r > key_rd_r);
    end
  end

  always_comb begin
    node_we      = 1'b0;
    node_wd      = next_r;
    next_nxt     = next_r;
    next_key_nxt = next_key_r;
    if (cmd.cmp_step) begin
      if (held_r == NODE_UNSET) begin
        node_we  = 1'b1;
        node_wd  = next_r;
        next_nxt = NODE_UNSET;
      end else if (next_r == NODE_EXHAUSTED) begin
        node_we      = 1'b1;
        node_wd      = NODE_EXHAUSTED;
        next_nxt     = held_r;
        next_key_nxt = key_rd_r;
      end else if ((held_r == NODE_EXHAUSTED) || (next_r == NODE_UNSET)) begin
        node_we = 1'b0;
      end else if (arr_loses) begin
        node_we      = 1'b1;
        node_wd      = next_r;
        next_nxt     = held_r;
        next_key_nxt = key_rd_r;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_vld_r    <= '0;
      node_rd_vld_r <= 1'b0;
      way_live_r    <= '0;
      node0_r       <= NODE_UNSET;
      out_valid_r   <= 1'b0;
    end else begin
      node_rd_vld_r <= node_vld_r[node_raddr];
      if (cmd.accept && !in_kind) begin
        node_vld_r <= '0;
        way_live_r <= '0;
        node0_r    <= NODE_UNSET;
      end else begin
        if (cmd.accept && sts.head_replay) begin
          way_live_r[in_way] <= in_has_key;
        end
        if (node_we) begin
          node_vld_r[parent_r] <= 1'b1;
        end
        if (cmd.finish) begin
          node0_r <= next_r;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      parent_r   <= first_parent;
      next_r     <= in_has_key ? NODE_W'(in_way) : NODE_EXHAUSTED;
      next_key_r <= in_has_key ? in_key : '0;
    end else begin
      if (cmd.cmp_step) begin
        parent_r <= parent_up;
      end
      next_r     <= next_nxt;
      next_key_r <= next_key_nxt;
    end
    if (cmd.rd_key) begin
      held_r <= held_c;
    end
    if (cmd.finish) begin
      win_key_r <= next_key_r;
    end
  end

  // Result from the winner at the root.
  assign top_live = (node0_r < NODE_UNSET) && way_live_r[node0_r[WAY_W-1:0]];

  always_comb begin
    if (node0_r == NODE_UNSET) begin
      res_status = STATUS_NOT_READY;
    end else if (!top_live) begin
      res_status = STATUS_EXHAUSTED;
    end else begin
      res_status = STATUS_WINNER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status;
      out_way_r    <= (res_status == STATUS_WINNER) ? node0_r[WAY_W-1:0] : '0;
      out_key_r    <= (res_status == STATUS_WINNER) ? win_key_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_winner_way = out_way_r;
  assign out_winner_key = out_key_r;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the loser-tree k-way merge selector
// Drives start and head items through the valid/stall input channel and keeps
// its own loser tree in step with the block. Each accepted item queues the
// winner that the tree should report. A checker process compares every
// accepted result field by field with the oldest queued winner. The ways
// register is written only while the block is idle, over its full range.
// ----------------------------------------------------------------------------
module tb;
  import ltkm_pkg::*;

  localparam int NWAYS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_HEAD  = 1'b1;
  localparam logic [3:0] NODE_UNSET     = 4'd8;
  localparam logic [3:0] NODE_EXHAUSTED = 4'd9;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  way;
    logic [31:0] key;
  } merge_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_ways_in_use = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [2:0]  in_way = 3'd0;
  logic        in_has_key = 1'b0;
  logic [31:0] in_key = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_winner_way;
  logic [31:0] out_winner_key;

  // Tree kept by the bench: node 0 holds the winner, the rest hold losers.
  logic [3:0]  tree_node [NWAYS];
  logic [31:0] head_key [NWAYS];
  logic        way_has_key [NWAYS];
  logic [3:0]  ways_reg;

  merge_result_t pending_results[$];

  int   err_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   merges_run = 0;
  int   merges_exhausted = 0;
  int   cycle_count = 0;
  logic [15:0] ways_seen = '0;

  logic burst_idle = 1'b1;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  loser_tree_kway_merge_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_ways_in_use(cfg_ways_in_use),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_way         (in_way),
    .in_has_key     (in_has_key),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_winner_way (out_winner_way),
    .out_winner_key (out_winner_key)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tree model
  // ------------------------------------------------------------------------
  function automatic int eff_ways();
    if (ways_reg == 4'd0) return 1;
    if (ways_reg > 4'(NWAYS)) return NWAYS;
    return int'(ways_reg);
  endfunction

  // True when the climbing way a must give way to the resident way b.
  // A way without a key loses to any keyed way; equal keys favor a.
  function automatic bit yields(logic [3:0] a, logic [3:0] b);
    if (!way_has_key[a[2:0]]) return way_has_key[b[2:0]];
    if (!way_has_key[b[2:0]]) return 1'b0;
    return head_key[a[2:0]] > head_key[b[2:0]];
  endfunction

  function automatic void replay_path(int w, int n);
    int parent;
    logic [3:0] climber;
    logic [3:0] held;
    parent = (w + n) >> 1;
    climber = way_has_key[w] ? 4'(w) : NODE_EXHAUSTED;
    while (parent > 0) begin
      held = tree_node[parent];
      if (held == NODE_UNSET) begin
        tree_node[parent] = climber;
        climber = NODE_UNSET;
      end else if (climber == NODE_EXHAUSTED) begin
        climber = held;
        tree_node[parent] = NODE_EXHAUSTED;
      end else if (held != NODE_EXHAUSTED && climber != NODE_UNSET) begin
        if (yields(climber, held)) begin
          tree_node[parent] = climber;
          climber = held;
        end
      end
      parent = parent >> 1;
    end
    tree_node[0] = climber;
  endfunction

  function automatic bit winner_live();
    return tree_node[0] < 4'(NWAYS) && way_has_key[tree_node[0][2:0]];
  endfunction

  function automatic merge_result_t predict_merge(logic kind, logic [2:0] way,
                                                  logic has_key, logic [31:0] key);
    merge_result_t r;
    int n;
    n = eff_ways();
    if (kind == KIND_START) begin
      for (int i = 0; i < NWAYS; i++) begin
        tree_node[i] = NODE_UNSET;
        way_has_key[i] = 1'b0;
      end
    end else if (int'(way) < n) begin
      way_has_key[way] = has_key;
      head_key[way] = has_key ? key : 32'd0;
      replay_path(int'(way), n);
    end
    r.way = '0;
    r.key = '0;
    if (tree_node[0] == NODE_UNSET) begin
      r.status = STATUS_NOT_READY;
    end else if (!winner_live()) begin
      r.status = STATUS_EXHAUSTED;
    end else begin
      r.status = STATUS_WINNER;
      r.way = tree_node[0][2:0];
      r.key = head_key[tree_node[0][2:0]];
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Result side: stalls and checking
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (burst_idle && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("MISMATCH at cycle %0d, result %0d: %s got %0h, expected %0h",
             cycle_count, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    merge_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_winner_way !== want.way)
          report_mismatch("winner_way", 32'(out_winner_way), 32'(want.way));
        if (out_winner_key !== want.key)
          report_mismatch("winner_key", out_winner_key, want.key);
      end
      results_seen++;
    end
  end

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------
  // Valid stays high after acceptance so that back-to-back items need no
  // second assignment in the same step; wait_idle lowers it.
  task automatic send_item(logic kind, logic [2:0] way, logic has_key, logic [31:0] key);
    if (burst_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_way <= way;
    in_has_key <= has_key;
    in_key <= key;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_merge(kind, way, has_key, key));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_ways(logic [3:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_ways_in_use <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ways_reg = value;
    ways_seen[value] = 1'b1;
  endtask

  // Small keys make ties common; the rest spread over the whole range.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1: return 32'($urandom_range(0, 7));
      2:    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8)
      send_item(($urandom_range(0, 15) == 0) ? KIND_START : KIND_HEAD,
                3'($urandom), 1'($urandom), pick_key());
  endtask

  // One merge pass: fill every way in random order, then keep replacing the
  // winner's head with its key plus 0 to 64 or exhausting it.
  task automatic run_merge(bit fresh);
    int n;
    int w;
    int j;
    int tmp;
    int steps;
    int order [NWAYS];
    n = eff_ways();
    if (fresh) send_item(KIND_START, 3'($urandom), 1'($urandom), $urandom);
    for (w = 0; w < n; w++) order[w] = w;
    for (w = n - 1; w > 0; w--) begin
      j = $urandom_range(0, w);
      tmp = order[w];
      order[w] = order[j];
      order[j] = tmp;
    end
    for (w = 0; w < n; w++) begin
      send_item(KIND_HEAD, 3'(order[w]), $urandom_range(0, 9) != 0, pick_key());
      maybe_noise();
    end
    steps = 0;
    while (winner_live() && steps < 6 * n + 4) begin
      w = int'(tree_node[0]);
      if ($urandom_range(0, 4) == 0)
        send_item(KIND_HEAD, 3'(w), 1'b0, $urandom);
      else
        send_item(KIND_HEAD, 3'(w), 1'b1, head_key[w] + 32'($urandom_range(0, 64)));
      maybe_noise();
      steps++;
    end
    merges_run++;
    if (tree_node[0] != NODE_UNSET && !winner_live()) merges_exhausted++;
  endtask

  function automatic logic [3:0] pick_ways();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd1;
      3: return 4'd8;
      default: return 4'($urandom_range(2, 8));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Eight ways: extreme keys, an exhausted way, ties, then exhaust all.
  task automatic test_extremes_and_ties();
    send_item(KIND_START, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_item(KIND_HEAD, 3'd0, 1'b1, 32'hFFFF_FFFF);
    send_item(KIND_HEAD, 3'd1, 1'b1, 32'd0);
    send_item(KIND_HEAD, 3'd2, 1'b1, 32'd5);
    send_item(KIND_HEAD, 3'd3, 1'b1, 32'd5);
    send_item(KIND_HEAD, 3'd4, 1'b0, 32'hFFFF_FFFF);
    send_item(KIND_HEAD, 3'd5, 1'b1, 32'd5);
    send_item(KIND_HEAD, 3'd6, 1'b1, 32'd7);
    send_item(KIND_HEAD, 3'd7, 1'b1, 32'h8000_0000);
    send_item(KIND_HEAD, 3'd1, 1'b0, 32'd0);
    // The arriving way wins a tie against the ways already holding key 5.
    send_item(KIND_HEAD, 3'd1, 1'b1, 32'd5);
    for (int w = 0; w < NWAYS; w++) send_item(KIND_HEAD, 3'(w), 1'b0, 32'hA5A5_5A5A);
  endtask

  // Register extremes, ignored ways and a change of width without a start.
  task automatic test_ways_register();
    set_ways(4'd0);
    send_item(KIND_START, 3'd0, 1'b0, 32'd0);
    send_item(KIND_HEAD, 3'd0, 1'b1, 32'd9);
    send_item(KIND_HEAD, 3'd5, 1'b1, 32'd1);
    send_item(KIND_HEAD, 3'd0, 1'b0, 32'd0);
    set_ways(4'd3);
    send_item(KIND_HEAD, 3'd1, 1'b1, 32'd2);
    send_item(KIND_HEAD, 3'd2, 1'b1, 32'd1);
    send_item(KIND_HEAD, 3'd0, 1'b1, 32'd3);
    send_item(KIND_HEAD, 3'd7, 1'b1, 32'd0);
    set_ways(4'd15);
    run_merge(1'b1);
    set_ways(4'd1);
    run_merge(1'b1);
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    set_ways(4'd8);
    burst_idle <= 1'b0;
    hold_req <= hold_req + 1;
    @(posedge clk);
    run_merge(1'b1);
    burst_idle <= 1'b1;
  endtask

  task automatic test_random_merges();
    while (items_sent < 1400) begin
      if ($urandom_range(0, 3) == 0) set_ways(pick_ways());
      run_merge($urandom_range(0, 7) != 0);
    end
  endtask

  // Last stretch with no idling on either side.
  task automatic test_steady_stream();
    set_ways(4'd8);
    burst_idle <= 1'b0;
    while (items_sent < 1790) run_merge(1'b1);
  endtask

  initial begin
    for (int i = 0; i < NWAYS; i++) begin
      tree_node[i] = NODE_UNSET;
      head_key[i] = 32'd0;
      way_has_key[i] = 1'b0;
    end
    ways_reg = CFG_WAYS_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes_and_ties();
    test_ways_register();
    test_backpressure();
    test_random_merges();
    test_steady_stream();
    wait_idle();

    $display("Sent %0d items and checked %0d results over %0d merge passes.",
             items_sent, results_seen, merges_run);
    $display("%0d passes ran to exhaustion; ways register values used: %b.",
             merges_exhausted, ways_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> loser_tree_kway_merge_top.f
rtl/core/ltkm_pkg.sv
rtl/core/ltkm_ctrl.sv
rtl/core/ltkm_dpath.sv
rtl/core/loser_tree_kway_merge_top.sv
tb/tb.sv
